@@ rtl/pmtf_pkg.sv @@
// ----------------------------------------------------------------------------
// pmtf_pkg
// shared beat types, token descriptor, buffer write port and result patterns
// ----------------------------------------------------------------------------
package pmtf_pkg;

  // length and index fields are sized for the largest token buffer (64)
  localparam int unsigned TOK_LEN_W = 7;
  localparam int unsigned TOK_IDX_W = 6;
  localparam int unsigned PAT_NUM   = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_game;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic       token_last;
    logic       token_truncated;
  } out_beat_t;

  // one kept token waiting in a buffer bank
  typedef struct packed {
    logic                 bank;
    logic [TOK_LEN_W-1:0] len;
    logic                 ovf;
  } tok_desc_t;

  // write into the token buffer
  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [TOK_IDX_W-1:0] idx;
    logic [7:0]           data;
  } buf_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    PAT_WHITE = 2'd0,
    PAT_BLACK = 2'd1,
    PAT_DRAW  = 2'd2,
    PAT_OPEN  = 2'd3
  } pattern_e;

  // game result strings that are dropped as tokens
  function automatic logic [2:0] pat_len(pattern_e p);
    logic [2:0] n;
    unique case (p)
      PAT_WHITE: n = 3'd3;
      PAT_BLACK: n = 3'd3;
      PAT_DRAW:  n = 3'd7;
      PAT_OPEN:  n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pat_char(pattern_e p, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (p)
      PAT_WHITE: begin
        unique case (pos)
          3'd0:    ch = "1";
          3'd1:    ch = "-";
          3'd2:    ch = "0";
          default: ch = 8'h00;
        endcase
      end
      PAT_BLACK: begin
        unique case (pos)
          3'd0:    ch = "0";
          3'd1:    ch = "-";
          3'd2:    ch = "1";
          default: ch = 8'h00;
        endcase
      end
      PAT_DRAW: begin
        unique case (pos)
          3'd0:    ch = "1";
          3'd1:    ch = "/";
          3'd2:    ch = "2";
          3'd3:    ch = "-";
          3'd4:    ch = "1";
          3'd5:    ch = "/";
          3'd6:    ch = "2";
          default: ch = 8'h00;
        endcase
      end
      PAT_OPEN: begin
        unique case (pos)
          3'd0:    ch = "*";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/pmtf_front.sv @@
// ----------------------------------------------------------------------------
// pmtf_front
// classifies text bytes, tracks nesting and builds tokens in a buffer bank
// ----------------------------------------------------------------------------
module pmtf_front #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned DEPTH_WIDTH   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  pmtf_pkg::in_beat_t  in_data_i,
  output logic                push_o,
  output pmtf_pkg::tok_desc_t desc_o,
  output pmtf_pkg::buf_wr_t   wr_o
);
  import pmtf_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic signed [DEPTH_WIDTH-1:0] DMAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
  localparam logic signed [DEPTH_WIDTH-1:0] DMIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};

  function automatic logic signed [DEPTH_WIDTH-1:0] sat_move(
    logic signed [DEPTH_WIDTH-1:0] v, logic up);
    logic signed [DEPTH_WIDTH-1:0] r;
    r = v;
    if (up) begin
      if (v != DMAX) r = v + DEPTH_WIDTH'(1);
    end else begin
      if (v != DMIN) r = v - DEPTH_WIDTH'(1);
    end
    return r;
  endfunction

  function automatic logic is_pos(logic signed [DEPTH_WIDTH-1:0] v);
    return !v[DEPTH_WIDTH-1] && (v != '0);
  endfunction

  logic signed [DEPTH_WIDTH-1:0] cmt_q, cmt_d, var_q, var_d, tag_q, tag_d;
  logic                          open_q, open_d;
  logic [LEN_W-1:0]              len_q, len_d;
  logic                          dot_q, dot_d;
  logic                          ovf_q, ovf_d;
  logic [PAT_NUM-1:0]            match_q, match_d;
  logic                          bank_q, bank_d;

  logic [7:0]         c;
  logic               eog, ws, opener, is_brk, any_pos;
  logic               start, append, close, move, room, keep;
  logic [LEN_W-1:0]   len_base, len_a, tok_len;
  logic               dot_base, ovf_base, dot_a, ovf_a, tok_dot, tok_ovf;
  logic [PAT_NUM-1:0] match_base, match_a, tok_match, hit;

  always_comb begin
    c       = in_data_i.text_byte;
    eog     = in_data_i.end_of_game;
    ws      = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    opener  = (c == CH_LBRACE) || (c == CH_LPAREN) || (c == CH_LBRACK);
    is_brk  = opener || (c == CH_RBRACE) || (c == CH_RPAREN) || (c == CH_RBRACK);
    any_pos = is_pos(cmt_q) || is_pos(var_q) || is_pos(tag_q);

    start  = accept_i && !open_q && !is_brk && !any_pos && !ws;
    append = start || (accept_i && open_q && !ws && !opener);
    close  = (accept_i && open_q && (ws || opener)) || (accept_i && eog && (open_q || start));
    move   = accept_i && ((!open_q && is_brk) || (open_q && opener));

    // a new token starts from an empty buffer
    len_base   = start ? '0 : len_q;
    dot_base   = start ? 1'b0 : dot_q;
    ovf_base   = start ? 1'b0 : ovf_q;
    match_base = start ? '1 : match_q;

    room  = len_base < LEN_W'(MAX_TOKEN_LEN);
    len_a = room ? len_base + LEN_W'(1) : len_base;
    ovf_a = ovf_base || !room;
    dot_a = dot_base || (c == CH_DOT);
    for (int unsigned k = 0; k < PAT_NUM; k++) begin
      match_a[k] = match_base[k] && room &&
                   (len_base < LEN_W'(pat_len(pattern_e'(k[1:0])))) &&
                   (c == pat_char(pattern_e'(k[1:0]), len_base[2:0]));
    end

    tok_len   = append ? len_a   : len_q;
    tok_dot   = append ? dot_a   : dot_q;
    tok_ovf   = append ? ovf_a   : ovf_q;
    tok_match = append ? match_a : match_q;
    for (int unsigned k = 0; k < PAT_NUM; k++) begin
      hit[k] = tok_match[k] && !tok_ovf &&
               (tok_len == LEN_W'(pat_len(pattern_e'(k[1:0]))));
    end
    keep = close && !tok_dot && (hit == '0);

    push_o      = keep;
    desc_o.bank = bank_q;
    desc_o.len  = TOK_LEN_W'(tok_len);
    desc_o.ovf  = tok_ovf;

    wr_o.en   = append && room;
    wr_o.bank = bank_q;
    wr_o.idx  = TOK_IDX_W'(len_base);
    wr_o.data = c;

    open_d  = open_q;
    len_d   = len_q;
    dot_d   = dot_q;
    ovf_d   = ovf_q;
    match_d = match_q;
    bank_d  = keep ? !bank_q : bank_q;
    if (close) begin
      open_d  = 1'b0;
      len_d   = '0;
      dot_d   = 1'b0;
      ovf_d   = 1'b0;
      match_d = '0;
    end else if (append) begin
      open_d  = 1'b1;
      len_d   = len_a;
      dot_d   = dot_a;
      ovf_d   = ovf_a;
      match_d = match_a;
    end

    cmt_d = cmt_q;
    var_d = var_q;
    tag_d = tag_q;
    if (accept_i && eog) begin
      cmt_d = '0;
      var_d = '0;
      tag_d = '0;
    end else if (move) begin
      if (c == CH_LBRACE || c == CH_RBRACE) cmt_d = sat_move(cmt_q, c == CH_LBRACE);
      if (c == CH_LPAREN || c == CH_RPAREN) var_d = sat_move(var_q, c == CH_LPAREN);
      if (c == CH_LBRACK || c == CH_RBRACK) tag_d = sat_move(tag_q, c == CH_LBRACK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmt_q   <= '0;
      var_q   <= '0;
      tag_q   <= '0;
      open_q  <= 1'b0;
      len_q   <= '0;
      dot_q   <= 1'b0;
      ovf_q   <= 1'b0;
      match_q <= '0;
      bank_q  <= 1'b0;
    end else begin
      cmt_q   <= cmt_d;
      var_q   <= var_d;
      tag_q   <= tag_d;
      open_q  <= open_d;
      len_q   <= len_d;
      dot_q   <= dot_d;
      ovf_q   <= ovf_d;
      match_q <= match_d;
      bank_q  <= bank_d;
    end
  end

`ifndef SYNTH
  a_open_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (len_q != '0))
    else $error("open token with zero length");

  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (!dot_q && !ovf_q && (len_q == '0)))
    else $error("token flags left set with no open token");
`endif

endmodule

@@ rtl/pmtf_queue.sv @@
// ----------------------------------------------------------------------------
// pmtf_queue
// two-entry queue of kept token descriptors, one per buffer bank
// ----------------------------------------------------------------------------
module pmtf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pmtf_pkg::tok_desc_t desc_i,
  input  logic                pop_i,
  output pmtf_pkg::tok_desc_t head_o,
  output pmtf_pkg::q_status_t status_o
);
  import pmtf_pkg::*;

  tok_desc_t  ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? !wp_q : wp_q;
    rp_d  = pop_i ? !rp_q : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
    head_o         = ent_q[rp_q];
    status_o.full  = cnt_q == 2'd2;
    status_o.empty = cnt_q == 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= desc_i;
  end

endmodule

@@ rtl/pmtf_back.sv @@
// ----------------------------------------------------------------------------
// pmtf_back
// token buffer memory and byte emitter with registered output
// ----------------------------------------------------------------------------
module pmtf_back #(
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmtf_pkg::buf_wr_t   wr_i,
  input  pmtf_pkg::tok_desc_t head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pmtf_pkg::out_beat_t out_data_o
);
  import pmtf_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TOKEN_LEN);

  logic [7:0]       mem [2**(IDX_W+1)];
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  out_beat_t        data_q;
  logic             load, last;
  logic [IDX_W:0]   rd_addr;

  always_comb begin
    load    = head_valid_i && (!valid_q || !out_stall_i);
    last    = (TOK_LEN_W'(idx_q) + TOK_LEN_W'(1)) == head_i.len;
    rd_addr = {head_i.bank, idx_q};
    pop_o   = load && last;
    idx_d   = idx_q;
    if (load) idx_d = last ? '0 : idx_q + IDX_W'(1);
    valid_d = load || (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[{wr_i.bank, wr_i.idx[IDX_W-1:0]}] <= wr_i.data;
  end

  // read data lands straight in the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q.token_char      <= mem[rd_addr];
      data_q.token_last      <= last;
      data_q.token_truncated <= head_i.ovf;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/pgn_movetext_token_filter.sv @@
// ----------------------------------------------------------------------------
// pgn_movetext_token_filter
// move-token filter for game movetext: skips brackets, numbers and results
// ----------------------------------------------------------------------------
// path: first byte of a kept token goes through the descriptor queue and the output
// register once its closing beat is accepted, when the back is idle
// throughput: one text byte per cycle while a token buffer bank is free
// output: one token byte per cycle unless out_stall_i holds it, set by the single buffer read port
// input stalls while both buffer banks hold tokens not yet sent
// reset: async active low clears counters, token state, queue and output valid
module pgn_movetext_token_filter #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned DEPTH_WIDTH   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pmtf_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pmtf_pkg::out_beat_t out_data_o
);
  import pmtf_pkg::*;

  // token buffer needs no clearing pass; only written entries are ever read

  logic      accept;
  logic      push, pop;
  tok_desc_t desc, head;
  buf_wr_t   wr;
  q_status_t qst;

  // front holds off whenever both banks are taken
  assign in_stall_o = qst.full;
  assign accept     = in_valid_i && !in_stall_o;

  // front: nesting counters, token assembly, result/move-number drop
  pmtf_front #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .DEPTH_WIDTH   (DEPTH_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .desc_o    (desc),
    .wr_o      (wr)
  );

  // queue of kept tokens between the two halves
  pmtf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (desc),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (qst)
  );

  // back: reads the token bank and sends one beat per byte
  pmtf_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .head_i       (head),
    .head_valid_i (!qst.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTH
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qst.full)
    else $error("token pushed into full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qst.empty)
    else $error("token popped from empty queue");
`endif

endmodule

@@ test/pmtf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmtf_checker
// watches both channels of the movetext token filter, predicts the kept token
// bytes from every accepted text beat and compares them with the output beats
// ----------------------------------------------------------------------------
module pmtf_checker #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned DEPTH_WIDTH   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  pmtf_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  pmtf_pkg::out_beat_t out_data_i,
  output int                  err_count_o,
  output int                  waiting_o
);

  import pmtf_pkg::*;

  typedef logic signed [DEPTH_WIDTH-1:0] level_t;

  localparam level_t LEVEL_TOP    = level_t'((1 << (DEPTH_WIDTH - 1)) - 1);
  localparam level_t LEVEL_BOTTOM = level_t'(-(1 << (DEPTH_WIDTH - 1)));

  localparam logic [7:0]  BRACE_OPEN   = "{";
  localparam logic [7:0]  BRACE_CLOSE  = "}";
  localparam logic [7:0]  PAREN_OPEN   = "(";
  localparam logic [7:0]  PAREN_CLOSE  = ")";
  localparam logic [7:0]  SQUARE_OPEN  = "[";
  localparam logic [7:0]  SQUARE_CLOSE = "]";
  localparam logic [7:0]  DOT_CHAR     = ".";
  localparam logic [7:0]  SPACE_CHAR   = 8'd32;
  localparam logic [7:0]  TAB_CHAR     = 8'd9;
  localparam logic [7:0]  CR_CHAR      = 8'd13;
  localparam logic [23:0] RES_WHITE    = "1-0";
  localparam logic [23:0] RES_BLACK    = "0-1";
  localparam logic [55:0] RES_DRAW     = "1/2-1/2";
  localparam logic [7:0]  RES_OPEN     = "*";

  level_t      brace_lvl  = '0;
  level_t      paren_lvl  = '0;
  level_t      square_lvl = '0;
  logic [7:0]  tok_buf [MAX_TOKEN_LEN];
  int unsigned tok_len  = 0;
  bit          tok_open = 1'b0;
  bit          tok_dot  = 1'b0;
  bit          tok_cut  = 1'b0;
  out_beat_t   kept_q [$];
  int          mismatches = 0;

  function automatic bit is_space(logic [7:0] c);
    return c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR);
  endfunction

  function automatic bit is_opener(logic [7:0] c);
    return c == BRACE_OPEN || c == PAREN_OPEN || c == SQUARE_OPEN;
  endfunction

  function automatic level_t nudge(level_t v, bit up);
    if (up) begin
      return (v == LEVEL_TOP) ? v : level_t'(v + 1);
    end
    return (v == LEVEL_BOTTOM) ? v : level_t'(v - 1);
  endfunction

  // truncated tokens never count as a game result
  function automatic bit is_game_result();
    if (tok_cut) begin
      return 1'b0;
    end
    case (tok_len)
      1: return tok_buf[0] == RES_OPEN;
      3: return {tok_buf[0], tok_buf[1], tok_buf[2]} == RES_WHITE ||
                {tok_buf[0], tok_buf[1], tok_buf[2]} == RES_BLACK;
      7: return {tok_buf[0], tok_buf[1], tok_buf[2], tok_buf[3],
                 tok_buf[4], tok_buf[5], tok_buf[6]} == RES_DRAW;
      default: return 1'b0;
    endcase
  endfunction

  task automatic move_level(input logic [7:0] c, output bit hit);
    hit = 1'b1;
    case (c)
      BRACE_OPEN:   brace_lvl  = nudge(brace_lvl, 1'b1);
      BRACE_CLOSE:  brace_lvl  = nudge(brace_lvl, 1'b0);
      PAREN_OPEN:   paren_lvl  = nudge(paren_lvl, 1'b1);
      PAREN_CLOSE:  paren_lvl  = nudge(paren_lvl, 1'b0);
      SQUARE_OPEN:  square_lvl = nudge(square_lvl, 1'b1);
      SQUARE_CLOSE: square_lvl = nudge(square_lvl, 1'b0);
      default:      hit = 1'b0;
    endcase
  endtask

  task automatic take_char(input logic [7:0] c);
    if (tok_len < MAX_TOKEN_LEN) begin
      tok_buf[tok_len] = c;
      tok_len++;
    end else begin
      tok_cut = 1'b1;
    end
    if (c == DOT_CHAR) begin
      tok_dot = 1'b1;
    end
  endtask

  task automatic close_token();
    bit        keep;
    out_beat_t e;
    keep = tok_open && tok_len > 0 && !tok_dot && !is_game_result();
    if (keep) begin
      for (int i = 0; i < tok_len; i++) begin
        e.token_char      = tok_buf[i];
        e.token_last      = (i + 1 == tok_len);
        e.token_truncated = tok_cut;
        kept_q.insert(kept_q.size(), e);
      end
    end
    tok_open = 1'b0;
    tok_len  = 0;
    tok_dot  = 1'b0;
    tok_cut  = 1'b0;
  endtask

  task automatic filter_text_byte(input in_beat_t b);
    logic [7:0] c;
    bit         hit;
    c = b.text_byte;
    if (tok_open) begin
      if (is_space(c) || is_opener(c)) begin
        close_token();
        move_level(c, hit);
      end else begin
        take_char(c);
      end
    end else begin
      move_level(c, hit);
      if (!hit && !(brace_lvl > 0 || paren_lvl > 0 || square_lvl > 0) && !is_space(c)) begin
        tok_open = 1'b1;
        tok_len  = 0;
        tok_dot  = 1'b0;
        tok_cut  = 1'b0;
        take_char(c);
      end
    end
    if (b.end_of_game) begin
      if (tok_open) begin
        close_token();
      end
      brace_lvl  = '0;
      paren_lvl  = '0;
      square_lvl = '0;
    end
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (kept_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("checker: unexpected beat char %h last %b trunc %b",
                 got.token_char, got.token_last, got.token_truncated);
      end
    end else begin
      want = kept_q.pop_front();
      if (got.token_char !== want.token_char || got.token_last !== want.token_last ||
          got.token_truncated !== want.token_truncated) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("checker: mismatch char exp %h got %h, last exp %b got %b, trunc exp %b got %b",
                   want.token_char, got.token_char, want.token_last, got.token_last,
                   want.token_truncated, got.token_truncated);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brace_lvl  = '0;
      paren_lvl  = '0;
      square_lvl = '0;
      tok_len    = 0;
      tok_open   = 1'b0;
      tok_dot    = 1'b0;
      tok_cut    = 1'b0;
      kept_q.delete();
      mismatches  = 0;
      err_count_o = 0;
      waiting_o   = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        filter_text_byte(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_beat(out_data_i);
      end
      err_count_o = mismatches;
      waiting_o   = kept_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the movetext token filter: two short directed games, then random
// games of moves, numbers, results, comments, variations, tags, long tokens, noise
// plus two counter-limit games, sent in bursts against a patterned output stall
// ----------------------------------------------------------------------------
module tb;

  import pmtf_pkg::*;

  localparam int unsigned TOKEN_MAX     = 32;
  localparam int unsigned DEPTH_W       = 8;
  localparam int          TEXT_ITEMS    = 360;
  localparam int          DEEP_RUN      = 130;   // enough to hit the counter limits
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          SETTLE_CYCLES = 16;

  // token alphabets for the game builder
  localparam string MOVE_SET = "abcdefghNBRQKxO-=+#12345678";
  localparam string DIGITS   = "0123456789";
  localparam string TEXT_SET = "abcdefg hijk XYZ!?,;:.0123";
  localparam string CLOSERS  = ")}]";

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  int          err_count;
  int          waiting;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  int          stall_left   = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int          sent_items   = 0;
  int          game_idx     = 0;
  int          drain        = 0;
  in_beat_t    text_q [$];

  always #5 clk_i = ~clk_i;

  pgn_movetext_token_filter #(
    .MAX_TOKEN_LEN (TOKEN_MAX),
    .DEPTH_WIDTH   (DEPTH_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pmtf_checker #(
    .MAX_TOKEN_LEN (TOKEN_MAX),
    .DEPTH_WIDTH   (DEPTH_W)
  ) i_tok_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .err_count_o (err_count),
    .waiting_o   (waiting)
  );

  // ---------------------------------------------------------------------------
  // game builder: appends text beats to text_q
  // ---------------------------------------------------------------------------

  task automatic put(input logic [7:0] c);
    in_beat_t b;
    b.text_byte   = c;
    b.end_of_game = 1'b0;
    text_q.insert(text_q.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i]);
    end
  endtask

  // n bytes drawn from an alphabet
  task automatic put_word(input string set, input int n);
    repeat (n) begin
      put(set[$urandom_range(0, set.len() - 1)]);
    end
  endtask

  // mostly plain spaces, all other whitespace codes now and then
  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 7))
      5:       return 8'd9;
      6:       return 8'd10;
      7:       return 8'($urandom_range(11, 13));
      default: return 8'd32;
    endcase
  endfunction

  // separator after an element; sometimes none, so an opener can end a token
  task automatic put_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      put(pick_space());
    end else if (r < 17) begin
      repeat ($urandom_range(2, 4)) put(pick_space());
    end
  endtask

  // flag the final beat of the game
  task automatic mark_end();
    text_q[text_q.size() - 1].end_of_game = 1'b1;
  endtask

  task automatic build_game();
    int kind;
    int len;
    repeat ($urandom_range(3, 14)) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // plain move
        put_word(MOVE_SET, $urandom_range(1, 6));
      end else if (kind < 45) begin
        // move number, white or black side
        put_word(DIGITS, $urandom_range(1, 3));
        if ($urandom_range(0, 1) != 0) begin
          put_str(".");
        end else begin
          put_str("...");
        end
      end else if (kind < 50) begin
        case ($urandom_range(0, 3))
          0:       put_str("1-0");
          1:       put_str("0-1");
          2:       put_str("1/2-1/2");
          default: put_str("*");
        endcase
      end else if (kind < 58) begin
        // brace comment, sometimes nested
        put("{");
        put_word(TEXT_SET, $urandom_range(1, 12));
        if ($urandom_range(0, 3) == 0) begin
          put("{");
          put_word(TEXT_SET, $urandom_range(1, 4));
          put("}");
        end
        put("}");
      end else if (kind < 64) begin
        // variation holding a few moves, sometimes nested
        put("(");
        repeat ($urandom_range(1, 3)) begin
          put_word(MOVE_SET, $urandom_range(1, 5));
          put(" ");
        end
        if ($urandom_range(0, 3) == 0) begin
          put("(");
          put_word(MOVE_SET, $urandom_range(1, 4));
          put(")");
        end
        put(")");
      end else if (kind < 68) begin
        put("[");
        put_str("Site \"");
        put_word(TEXT_SET, $urandom_range(1, 6));
        put("\"");
        put("]");
      end else if (kind < 72) begin
        // long token around the buffer size, dot sometimes past the cut
        case ($urandom_range(0, 3))
          0:       len = TOKEN_MAX - 1;
          1:       len = TOKEN_MAX;
          2:       len = TOKEN_MAX + 1;
          default: len = $urandom_range(TOKEN_MAX + 2, TOKEN_MAX + 8);
        endcase
        put_word(MOVE_SET, len);
        if ($urandom_range(0, 2) == 0) begin
          put(".");
          put_word(MOVE_SET, 2);
        end
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
      end else if (kind < 83) begin
        // closing bracket stays inside a token
        put_word(MOVE_SET, $urandom_range(1, 4));
        put(CLOSERS[$urandom_range(0, 2)]);
        if ($urandom_range(0, 1) == 0) begin
          put_word(MOVE_SET, $urandom_range(1, 2));
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(128, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) put(pick_space());
      end
      put_gap();
    end
    // broken game: the text stops inside an open comment
    if ($urandom_range(0, 5) == 0) begin
      put("{");
      put_word(TEXT_SET, $urandom_range(1, 4));
    end
    mark_end();
  endtask

  // ---------------------------------------------------------------------------
  // sender: all calls start and end at a falling edge
  // ---------------------------------------------------------------------------

  // hold the beat until an edge sees valid without stall
  task automatic drive_beat(input in_beat_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // sends text_q in bursts; a gap holds valid low across a clock edge, so valid never
  // drops and rises within one step
  task automatic send_game();
    int gap;
    foreach (text_q[k]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          in_data_i  <= in_beat_t'($urandom);
          repeat (gap) @(negedge clk_i);
        end
        // long bursts give stretches with no idling
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
      end
      burst_left--;
      drive_beat(text_q[k]);
    end
    text_q.delete();
  endtask

  // ---------------------------------------------------------------------------
  // receiver stall: modes switch after a random number of cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_left % 7) < 3);
    endcase
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: kept move, move number ended by a comment, white result,
    // variation, closer inside a token, unmatched closer (negative counter
    // does not skip), opener ending a token on the last beat of the game
    put_str("e4 1.{x}1-0 (N)a) ]b(");
    mark_end();
    // extreme bytes form a token, tab ends it, open result flushed at game end
    put(8'h00);
    put(8'hFF);
    put(8'd9);
    put("*");
    mark_end();
    sent_items += text_q.size();
    send_game();

    // the two counter-limit games always run, random games fill the rest
    while (sent_items < TEXT_ITEMS || game_idx <= 3) begin
      if (game_idx == 1) begin
        // tag counter runs into its upper limit; everything after is skipped
        repeat (DEEP_RUN) put("[");
        put_str("] Nf3 e5");
        mark_end();
      end else if (game_idx == 3) begin
        // unmatched closers run the comment counter into its lower limit
        repeat (DEEP_RUN) put("}");
        put_str(" Nf3 {x} e5");
        mark_end();
      end else begin
        build_game();
      end
      sent_items += text_q.size();
      send_game();
      // every third game the sender waits until the output side catches up
      if (game_idx % 3 == 1) begin
        in_valid_i <= 1'b0;
        while (waiting != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
      game_idx++;
    end

    in_valid_i <= 1'b0;
    while (waiting != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (err_count == 0 && waiting == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
